FILE: hdl/cbst_pkg.sv
`timescale 1ns / 1ps
// Shared package for the cursor binary search tree.
// Holds default sizes, operation and status codes, sequencer states and control structs.
package cbst_pkg;

   localparam int NODE_COUNT_DEF = 64;
   localparam int KEY_BITS_DEF   = 32;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_FIND   = 3'd2;
   localparam logic [2:0] OP_MIN    = 3'd3;
   localparam logic [2:0] OP_MAX    = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [7:0] {
      SEQ_IDLE     = 8'b0000_0001,
      SEQ_WALK     = 8'b0000_0010,
      SEQ_VISIT    = 8'b0000_0100,
      SEQ_EXT_VIS  = 8'b0000_1000,
      SEQ_SCAN     = 8'b0001_0000,
      SEQ_INS_NODE = 8'b0010_0000,
      SEQ_INS_LINK = 8'b0100_0000,
      SEQ_DEL_MIN  = 8'b1000_0000
   } seq_state_type;

   // sequencer -> slot allocator
   typedef struct packed {
      logic scan_go;
      logic set_en;
      logic clr_en;
   } alloc_ctl_type;

   // slot allocator -> sequencer
   typedef struct packed {
      logic done;
      logic full;
   } alloc_stat_type;

endpackage

FILE: hdl/cbst_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/cbst_alloc.sv
`timescale 1ns / 1ps
// Slot allocator: per-slot used marks and a one-slot-per-cycle free-slot scan.
// Depends on cbst_pkg.
module cbst_alloc import cbst_pkg::*; #(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  alloc_ctl_type                 ctl,
   input  logic [$clog2(NODE_COUNT)-1:0] set_slot,
   input  logic [$clog2(NODE_COUNT)-1:0] clr_slot,
   output logic [NODE_COUNT-1:0]         used,
   output alloc_stat_type                stat,
   output logic [$clog2(NODE_COUNT)-1:0] free_slot
);

   localparam int IW = $clog2(NODE_COUNT);
   localparam logic [IW-1:0] LAST = IW'(NODE_COUNT - 1);

   logic [NODE_COUNT-1:0] used_ff, used_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  busy_ff, busy_in;
   logic                  done;

   assign done = busy_ff && (!used_ff[idx_ff] || idx_ff == LAST);

   always_comb begin
      used_in = used_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (ctl.set_en) begin
         used_in[set_slot] = 1'b1;
      end
      if (ctl.clr_en) begin
         used_in[clr_slot] = 1'b0;
      end
      if (ctl.scan_go) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         used_ff <= used_in;
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   assign used      = used_ff;
   assign stat.done = done;
   assign stat.full = used_ff[idx_ff];
   assign free_slot = idx_ff;

endmodule

FILE: hdl/cursor_binary_search_tree.sv
`timescale 1ns / 1ps
// Binary search tree over NODE_COUNT node slots kept in three RAMs (key, left link,
// right link), with used marks in flops. One transaction at a time: the sequencer walks the
// tree with one RAM read per cycle; find, minimum and maximum walk down from the root,
// delete also walks the successor path, and an insert of a new key adds a free-slot
// scan plus a node-write state and a link-write state (SEQ_INS_NODE, SEQ_INS_LINK). A
// finished result sits in an output register so the next transaction can be taken while
// it waits. Depends on cbst_pkg, cbst_ram, cbst_alloc.
module cursor_binary_search_tree import cbst_pkg::*; #(
   parameter int NODE_COUNT = NODE_COUNT_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_node_slot,
   output logic [31:0] rsp_key_out
);

   localparam int IW = $clog2(NODE_COUNT);
   localparam int LW = $clog2(NODE_COUNT + 1);
   localparam logic [LW-1:0] NONE = LW'(NODE_COUNT);

   seq_state_type state_ff, state_in;
   logic [2:0]          op_ff, op_in;
   logic [KEY_BITS-1:0] k_ff, k_in;
   logic [LW-1:0]       root_ff, root_in;
   logic [LW-1:0]       cur_ff, cur_in;
   logic [LW-1:0]       p_ff, p_in;
   logic                lft_ff, lft_in;
   logic [LW-1:0]       m_ff, m_in;
   logic [LW-1:0]       mp_ff, mp_in;
   logic [IW-1:0]       free_ff, free_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic [IW-1:0]       res_slot_ff, res_slot_in;
   logic [KEY_BITS-1:0] res_key_ff, res_key_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [5:0]          rsp_slot_ff, rsp_slot_in;
   logic [31:0]         rsp_key_ff, rsp_key_in;
   logic                res_pending_ff, res_pending_in;
   logic                finishing;

   logic [IW-1:0]       rd_addr;
   logic [KEY_BITS-1:0] key_rd;
   logic [LW-1:0]       left_rd, right_rd;
   logic                key_we, left_we, right_we;
   logic [IW-1:0]       key_wa, left_wa, right_wa;
   logic [KEY_BITS-1:0] key_wd;
   logic [LW-1:0]       left_wd, right_wd;
   logic                relink_en;
   logic [LW-1:0]       relink_child;
   logic [LW-1:0]       nx;
   logic                go_left;

   alloc_ctl_type         actl;
   alloc_stat_type        astat;
   logic [IW-1:0]         set_slot, clr_slot, scan_slot;
   logic [NODE_COUNT-1:0] used;

   function automatic logic is_node(input logic [LW-1:0] s);
      is_node = (s < NONE) && used[s[IW-1:0]];
   endfunction

   cbst_ram #(.WIDTH(KEY_BITS), .DEPTH(NODE_COUNT)) u_key_ram (
      .clock(clock), .we(key_we), .waddr(key_wa), .wdata(key_wd),
      .raddr(rd_addr), .rdata(key_rd)
   );

   cbst_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_left_ram (
      .clock(clock), .we(left_we), .waddr(left_wa), .wdata(left_wd),
      .raddr(rd_addr), .rdata(left_rd)
   );

   cbst_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_right_ram (
      .clock(clock), .we(right_we), .waddr(right_wa), .wdata(right_wd),
      .raddr(rd_addr), .rdata(right_rd)
   );

   cbst_alloc #(.NODE_COUNT(NODE_COUNT)) u_alloc (
      .clock(clock), .reset(reset), .ctl(actl), .set_slot(set_slot), .clr_slot(clr_slot),
      .used(used), .stat(astat), .free_slot(scan_slot)
   );

   assign req_ready = (state_ff == SEQ_IDLE) && !res_pending_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      k_in          = k_ff;
      root_in       = root_ff;
      cur_in        = cur_ff;
      p_in          = p_ff;
      lft_in        = lft_ff;
      m_in          = m_ff;
      mp_in         = mp_ff;
      free_in       = free_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_key_in    = res_key_ff;
      rd_addr       = cur_ff[IW-1:0];
      key_we        = 1'b0;
      key_wa        = free_ff;
      key_wd        = k_ff;
      left_we       = 1'b0;
      left_wa       = free_ff;
      left_wd       = NONE;
      right_we      = 1'b0;
      right_wa      = free_ff;
      right_wd      = NONE;
      relink_en     = 1'b0;
      relink_child  = NONE;
      actl          = '0;
      set_slot      = free_ff;
      clr_slot      = cur_ff[IW-1:0];
      go_left       = (k_ff < key_rd);
      nx            = NONE;

      // result registers are loaded whenever the sequencer lands in IDLE
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               op_in  = req_kind;
               k_in   = KEY_BITS'({{KEY_BITS{1'b0}}, req_key});
               cur_in = root_ff;
               p_in   = NONE;
               lft_in = 1'b0;
               if (req_kind == OP_INSERT || req_kind == OP_DELETE || req_kind == OP_FIND ||
                   req_kind == OP_MIN || req_kind == OP_MAX) begin
                  state_in = SEQ_WALK;
               end else begin
                  res_status_in = ST_MISS;
                  res_slot_in   = '0;
                  res_key_in    = '0;
               end
            end
         end
         SEQ_WALK: begin
            if (is_node(cur_ff)) begin
               state_in = (op_ff == OP_MIN || op_ff == OP_MAX) ? SEQ_EXT_VIS : SEQ_VISIT;
            end else if (op_ff == OP_INSERT) begin
               actl.scan_go = 1'b1;
               state_in     = SEQ_SCAN;
            end else begin
               res_status_in = ST_MISS;
               res_slot_in   = '0;
               res_key_in    = '0;
               state_in      = SEQ_IDLE;
            end
         end
         SEQ_VISIT: begin
            if (key_rd == k_ff) begin
               if (op_ff == OP_DELETE && is_node(left_rd) && is_node(right_rd)) begin
                  m_in     = right_rd;
                  mp_in    = cur_ff;
                  rd_addr  = right_rd[IW-1:0];
                  state_in = SEQ_DEL_MIN;
               end else begin
                  if (op_ff == OP_DELETE) begin
                     relink_en    = 1'b1;
                     relink_child = is_node(left_rd) ? left_rd :
                                    (is_node(right_rd) ? right_rd : NONE);
                     actl.clr_en  = 1'b1;
                  end
                  res_status_in = ST_OK;
                  res_slot_in   = cur_ff[IW-1:0];
                  res_key_in    = k_ff;
                  state_in      = SEQ_IDLE;
               end
            end else begin
               p_in   = cur_ff;
               lft_in = go_left;
               nx     = go_left ? left_rd : right_rd;
               if (is_node(nx)) begin
                  cur_in  = nx;
                  rd_addr = nx[IW-1:0];
               end else if (op_ff == OP_INSERT) begin
                  actl.scan_go = 1'b1;
                  state_in     = SEQ_SCAN;
               end else begin
                  res_status_in = ST_MISS;
                  res_slot_in   = '0;
                  res_key_in    = '0;
                  state_in      = SEQ_IDLE;
               end
            end
         end
         SEQ_EXT_VIS: begin
            nx = (op_ff == OP_MIN) ? left_rd : right_rd;
            if (is_node(nx)) begin
               cur_in  = nx;
               rd_addr = nx[IW-1:0];
            end else begin
               res_status_in = ST_OK;
               res_slot_in   = cur_ff[IW-1:0];
               res_key_in    = key_rd;
               state_in      = SEQ_IDLE;
            end
         end
         SEQ_SCAN: begin
            if (astat.done) begin
               if (astat.full) begin
                  res_status_in = ST_FULL;
                  res_slot_in   = '0;
                  res_key_in    = '0;
                  state_in      = SEQ_IDLE;
               end else begin
                  free_in  = scan_slot;
                  state_in = SEQ_INS_NODE;
               end
            end
         end
         SEQ_INS_NODE: begin
            key_we      = 1'b1;
            left_we     = 1'b1;
            right_we    = 1'b1;
            actl.set_en = 1'b1;
            state_in    = SEQ_INS_LINK;
         end
         SEQ_INS_LINK: begin
            relink_en     = 1'b1;
            relink_child  = LW'(free_ff);
            res_status_in = ST_OK;
            res_slot_in   = free_ff;
            res_key_in    = k_ff;
            state_in      = SEQ_IDLE;
         end
         SEQ_DEL_MIN: begin
            rd_addr = m_ff[IW-1:0];
            if (is_node(left_rd)) begin
               mp_in   = m_ff;
               m_in    = left_rd;
               rd_addr = left_rd[IW-1:0];
            end else begin
               // successor found: splice it out and move its key up
               if (mp_ff == cur_ff) begin
                  right_we = 1'b1;
                  right_wa = cur_ff[IW-1:0];
                  right_wd = right_rd;
               end else begin
                  left_we = 1'b1;
                  left_wa = mp_ff[IW-1:0];
                  left_wd = right_rd;
               end
               key_we        = 1'b1;
               key_wa        = cur_ff[IW-1:0];
               key_wd        = key_rd;
               actl.clr_en   = 1'b1;
               clr_slot      = m_ff[IW-1:0];
               res_status_in = ST_OK;
               res_slot_in   = cur_ff[IW-1:0];
               res_key_in    = k_ff;
               state_in      = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase

      if (relink_en) begin
         if (!is_node(p_ff)) begin
            root_in = relink_child;
         end else if (lft_ff) begin
            left_we = 1'b1;
            left_wa = p_ff[IW-1:0];
            left_wd = relink_child;
         end else begin
            right_we = 1'b1;
            right_wa = p_ff[IW-1:0];
            right_wd = relink_child;
         end
      end
   end

   // a pending result sits in res_*; it moves to the output register once that is free
   assign finishing = (state_ff != SEQ_IDLE) && (state_in == SEQ_IDLE);

   always_comb begin
      res_pending_in = res_pending_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_key_in     = rsp_key_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_pending_ff && !rsp_valid_in) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status_ff;
         rsp_slot_in    = 6'({6'b0, res_slot_ff});
         rsp_key_in     = 32'({32'b0, res_key_ff});
         res_pending_in = 1'b0;
      end
      if (finishing ||
          (state_ff == SEQ_IDLE && req_valid && req_ready && state_in == SEQ_IDLE)) begin
         res_pending_in = 1'b1;
      end
   end

   // a new transaction is only taken once the previous result left res_*
   logic stall_new;
   assign stall_new = res_pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SEQ_IDLE;
         root_ff        <= NONE;
         rsp_valid_ff   <= 1'b0;
         res_pending_ff <= 1'b0;
      end else begin
         if (!(state_ff == SEQ_IDLE && stall_new)) begin
            state_ff <= state_in;
            root_ff  <= root_in;
         end
         rsp_valid_ff   <= rsp_valid_in;
         res_pending_ff <= res_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!(state_ff == SEQ_IDLE && stall_new)) begin
         op_ff         <= op_in;
         k_ff          <= k_in;
         cur_ff        <= cur_in;
         p_ff          <= p_in;
         lft_ff        <= lft_in;
         res_status_ff <= res_status_in;
         res_slot_ff   <= res_slot_in;
         res_key_ff    <= res_key_in;
      end
      m_ff          <= m_in;
      mp_ff         <= mp_in;
      free_ff       <= free_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_node_slot = rsp_slot_ff;
   assign rsp_key_out   = rsp_key_ff;

   // the root link always names a live node or is null
   a_root_live: assert property (@(posedge clock) disable iff (reset)
      root_ff == NONE || is_node(root_ff))
      else $error("root link points at an unused slot");

   // the scan must hand over a slot that is really free
   a_ins_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_INS_NODE |-> !used[free_ff])
      else $error("insert into a used slot");

   // a new result only appears when one was pending
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(res_pending_ff))
      else $error("result shown without a pending result");

endmodule
